[design/sidechain_duck_mono_crossover_fir_assert.svh]
// Assertion macros used by the sidechain ducker top level.
`ifndef SIDECHAIN_DUCK_MONO_CROSSOVER_FIR_ASSERT_SVH
`define SIDECHAIN_DUCK_MONO_CROSSOVER_FIR_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define SCD_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("scd assertion failed");
// next-cycle implication
`define SCD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("scd assertion failed");
`else
`define SCD_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define SCD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[design/scdfir_pkg.sv]
// Package: constants, types and the tanh table for the sidechain ducker.
package scdfir_pkg;

	localparam int FIR_ORDER  = 64;
	localparam int TAPS       = FIR_ORDER + 1;
	localparam int CENTER_TAP = FIR_ORDER / 2;
	localparam int TAP_W      = $clog2(TAPS);
	localparam int CNT_W      = $clog2(TAPS + 1);
	localparam int DRY_DELAY  = 32;
	localparam int TANH_DEPTH = 256;
	localparam int TANH_LOG2  = $clog2(TANH_DEPTH);
	localparam int TANH_IDX_W = TANH_LOG2 + 1;
	localparam int TANH_SPAN  = 26;
	localparam int COEF_W     = 18;
	localparam int HPCOEF_W   = COEF_W + 2;
	localparam int SMP_W      = 24;
	localparam int ACC_W      = HPCOEF_W + SMP_W + TAP_W;
	localparam int FIRO_W     = ACC_W - 17;

	localparam logic [16:0] ONE_Q16 = 17'd65536;
	localparam logic signed [HPCOEF_W-1:0] UNIT_TAP = HPCOEF_W'(131072);

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_ATTACK  = 3'd0,
		CFG_RELEASE = 3'd1,
		CFG_DUCK    = 3'd2,
		CFG_WET     = 3'd3,
		CFG_DRIVE   = 3'd4,
		CFG_RECIP   = 3'd5,
		CFG_BLEND   = 3'd6,
		CFG_SHAPER  = 3'd7
	} cfg_reg_t;

	// item kinds
	localparam logic KIND_FRAME = 1'b0;
	localparam logic KIND_COEF  = 1'b1;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ENV,
		ST_ENV_UPD,
		ST_GAIN,
		ST_DUCK,
		ST_MONO,
		ST_DRIVE,
		ST_TANH,
		ST_INTERP,
		ST_BLEND,
		ST_NORM,
		ST_SHIFT,
		ST_FIR,
		ST_FIR_RND,
		ST_MIX,
		ST_OUT
	} state_t;

	// control from the sequencer to the tap chain
	typedef struct packed {
		logic             shift;
		logic             rotate;
		logic             clear;
		logic             rd_en;
		logic [TAP_W-1:0] rd_addr;
		logic [TAP_W-1:0] use_tap;
	} chain_ctrl_t;

	typedef logic signed [SMP_W-1:0] tanh_lut_t [TANH_DEPTH+1];

	// round half away from zero on a right shift
	function automatic logic signed [63:0] rshr(input logic signed [63:0] v, input int sh);
		logic signed [63:0] half;
		half = 64'sd1 <<< (sh - 1);
		return (v + half - ((v < 0) ? 64'sd1 : 64'sd0)) >>> sh;
	endfunction

	function automatic logic signed [SMP_W-1:0] sat24(input logic signed [63:0] v);
		if (v > 64'sd8388607) begin
			return 24'sh7FFFFF;
		end else if (v < -64'sd8388608) begin
			return 24'sh800000;
		end
		return v[SMP_W-1:0];
	endfunction

	// restoring long division, used only while building the table
	function automatic longint unsigned udiv64(input longint unsigned a, input longint unsigned b);
		longint unsigned q, r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], a[i]};
			if (r >= b) begin
				r    = r - b;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// tanh points over |x| in [0,8], Q30 series for exp(-2x)
	function automatic tanh_lut_t build_tanh_lut();
		tanh_lut_t          t;
		longint             y, n, z, num, den;
		longint unsigned    f, term;
		int                 i, k;
		for (i = 0; i <= TANH_DEPTH; i++) begin
			y = longint'(((64'd16 * longint'(i)) << 30) / TANH_DEPTH);
			n = y >>> 30;
			f = longint'(y) & ((64'd1 << 30) - 64'd1);
			z = longint'(64'd1 << 30);
			term = 64'd1 << 30;
			for (k = 1; k <= 16; k++) begin
				term = udiv64(term * f, $unsigned(64'(k)) << 30);
				if (k % 2 == 1) begin
					z = z - longint'(term);
				end else begin
					z = z + longint'(term);
				end
			end
			for (k = 0; k < n; k++) begin
				z = (z * 395007542 + (longint'(1) << 29)) >>> 30;
			end
			num = ((longint'(1) << 30) - z) << 23;
			den = (longint'(1) << 30) + z;
			t[i] = SMP_W'(udiv64($unsigned(num + (den >>> 1)), $unsigned(den)));
		end
		return t;
	endfunction

	localparam tanh_lut_t TANH_LUT = build_tanh_lut();

endpackage

[design/scdfir_cell.sv]
// One tap cell: holds a mid and a shaped history word.
module scdfir_cell (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  scdfir_pkg::chain_ctrl_t              ctrl,
	input  logic signed [scdfir_pkg::SMP_W-1:0]  left_mid,
	input  logic signed [scdfir_pkg::SMP_W-1:0]  left_shaped,
	input  logic signed [scdfir_pkg::SMP_W-1:0]  right_mid,
	input  logic signed [scdfir_pkg::SMP_W-1:0]  right_shaped,
	output logic signed [scdfir_pkg::SMP_W-1:0]  mid,
	output logic signed [scdfir_pkg::SMP_W-1:0]  shaped
);

	logic signed [scdfir_pkg::SMP_W-1:0] mid_q;
	logic signed [scdfir_pkg::SMP_W-1:0] shaped_q;

	// shift takes the neighbor's word on the head side, rotate the one on the tail side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q    <= '0;
			shaped_q <= '0;
		end else if (ctrl.shift) begin
			mid_q    <= left_mid;
			shaped_q <= left_shaped;
		end else if (ctrl.rotate) begin
			mid_q    <= right_mid;
			shaped_q <= right_shaped;
		end
	end

	assign mid    = mid_q;
	assign shaped = shaped_q;

endmodule

[design/scdfir_chain.sv]
// Tap chain: history cells, coefficient memory and the two serial MACs.
module scdfir_chain (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  scdfir_pkg::chain_ctrl_t               ctrl,
	input  logic signed [scdfir_pkg::SMP_W-1:0]   new_mid,
	input  logic signed [scdfir_pkg::SMP_W-1:0]   new_shaped,
	input  logic                                  coef_we,
	input  logic [scdfir_pkg::TAP_W-1:0]          coef_addr,
	input  logic signed [scdfir_pkg::COEF_W-1:0]  coef_data,
	output logic signed [scdfir_pkg::ACC_W-1:0]   acc_mid,
	output logic signed [scdfir_pkg::ACC_W-1:0]   acc_side
);

	logic signed [scdfir_pkg::SMP_W-1:0]    cell_mid    [scdfir_pkg::TAPS];
	logic signed [scdfir_pkg::SMP_W-1:0]    cell_shaped [scdfir_pkg::TAPS];
	logic signed [scdfir_pkg::COEF_W-1:0]   coef_mem    [scdfir_pkg::TAPS];
	logic signed [scdfir_pkg::COEF_W-1:0]   coef_rd_q;
	logic signed [scdfir_pkg::HPCOEF_W-1:0] hp_coef;
	logic signed [scdfir_pkg::ACC_W-1:0]    acc_mid_q;
	logic signed [scdfir_pkg::ACC_W-1:0]    acc_side_q;

	// row of cells; the head wraps to the tail on rotate
	for (genvar i = 0; i < scdfir_pkg::TAPS; i++) begin : g_cell
		logic signed [scdfir_pkg::SMP_W-1:0] lm, ls, rm, rs;
		if (i == 0) begin : g_head
			assign lm = new_mid;
			assign ls = new_shaped;
		end else begin : g_body
			assign lm = cell_mid[i-1];
			assign ls = cell_shaped[i-1];
		end
		if (i == scdfir_pkg::TAPS - 1) begin : g_tail
			assign rm = cell_mid[0];
			assign rs = cell_shaped[0];
		end else begin : g_inner
			assign rm = cell_mid[i+1];
			assign rs = cell_shaped[i+1];
		end
		scdfir_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctrl         (ctrl),
			.left_mid     (lm),
			.left_shaped  (ls),
			.right_mid    (rm),
			.right_shaped (rs),
			.mid          (cell_mid[i]),
			.shaped       (cell_shaped[i])
		);
	end

	// coefficient memory, registered read
	always_ff @(posedge clk) begin
		if (coef_we) begin
			coef_mem[coef_addr] <= coef_data;
		end
		if (ctrl.rd_en) begin
			coef_rd_q <= coef_mem[ctrl.rd_addr];
		end
	end

	// matching highpass tap: unit at the center minus lowpass
	always_comb begin
		hp_coef = -scdfir_pkg::HPCOEF_W'(coef_rd_q);
		if (ctrl.use_tap == scdfir_pkg::TAP_W'(scdfir_pkg::CENTER_TAP)) begin
			hp_coef = scdfir_pkg::UNIT_TAP - scdfir_pkg::HPCOEF_W'(coef_rd_q);
		end
	end

	// one tap per cycle off the head cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_mid_q  <= '0;
			acc_side_q <= '0;
		end else if (ctrl.clear) begin
			acc_mid_q  <= '0;
			acc_side_q <= '0;
		end else if (ctrl.rotate) begin
			acc_mid_q  <= acc_mid_q + scdfir_pkg::ACC_W'(coef_rd_q) *
				scdfir_pkg::ACC_W'(cell_mid[0]);
			acc_side_q <= acc_side_q + scdfir_pkg::ACC_W'(hp_coef) *
				scdfir_pkg::ACC_W'(cell_shaped[0]);
		end
	end

	assign acc_mid  = acc_mid_q;
	assign acc_side = acc_side_q;

endmodule

[design/sidechain_duck_mono_crossover_fir.sv]
// Top level: sidechain ducker with FIR crossover and waveshaper.
// Each accepted frame word runs through 14 sequencer steps plus one pass over the
// tap chain, one tap per cycle, before its result word is loaded.
// A new frame is taken only in idle, after the last result word is loaded; the serial
// MAC runs over the 65-tap chain; a coefficient word gives no result.
// Reset: asynchronous, sets config defaults, clears sequencer, envelope, histories, dry delay.
`include "sidechain_duck_mono_crossover_fir_assert.svh"
module sidechain_duck_mono_crossover_fir (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_addr,
	input  logic [16:0]          cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 kind,
	input  logic signed [23:0]   main_left,
	input  logic signed [23:0]   main_right,
	input  logic signed [23:0]   side_left,
	input  logic signed [23:0]   side_right,
	input  logic [6:0]           tap_index,
	input  logic signed [17:0]   tap_value,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [23:0]   out_left,
	output logic signed [23:0]   out_right,
	output logic [16:0]          duck_level,
	output logic [22:0]          sidechain_level
);

	// config registers
	logic [15:0] attack_q, release_q, drive_q;
	logic [16:0] duck_q, wet_q, recip_q, blend_q;
	logic        shaper_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= 16'd1000;
			release_q <= 16'd100;
			duck_q    <= 17'd0;
			wet_q     <= 17'd65536;
			drive_q   <= 16'd4096;
			recip_q   <= 17'd65536;
			blend_q   <= 17'd0;
			shaper_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_addr)
				scdfir_pkg::CFG_ATTACK:  attack_q  <= cfg_wdata[15:0];
				scdfir_pkg::CFG_RELEASE: release_q <= cfg_wdata[15:0];
				scdfir_pkg::CFG_DUCK:    duck_q    <= cfg_wdata;
				scdfir_pkg::CFG_WET:     wet_q     <= cfg_wdata;
				scdfir_pkg::CFG_DRIVE:   drive_q   <= cfg_wdata[15:0];
				scdfir_pkg::CFG_RECIP:   recip_q   <= cfg_wdata;
				scdfir_pkg::CFG_BLEND:   blend_q   <= cfg_wdata;
				scdfir_pkg::CFG_SHAPER:  shaper_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// gains above unity saturate
	logic [16:0] duck_cap, wet_cap, recip_cap, blend_cap, dry_share;
	assign duck_cap  = (duck_q  > scdfir_pkg::ONE_Q16) ? scdfir_pkg::ONE_Q16 : duck_q;
	assign wet_cap   = (wet_q   > scdfir_pkg::ONE_Q16) ? scdfir_pkg::ONE_Q16 : wet_q;
	assign recip_cap = (recip_q > scdfir_pkg::ONE_Q16) ? scdfir_pkg::ONE_Q16 : recip_q;
	assign blend_cap = (blend_q > scdfir_pkg::ONE_Q16) ? scdfir_pkg::ONE_Q16 : blend_q;
	assign dry_share = scdfir_pkg::ONE_Q16 - wet_cap;

	scdfir_pkg::state_t state_q, state_d;
	logic                          in_acc, frame_acc, out_load, out_take;
	logic [scdfir_pkg::CNT_W-1:0]  cnt_q;
	scdfir_pkg::chain_ctrl_t       chain_ctrl;

	assign in_acc    = in_valid && !in_stall;
	assign frame_acc = in_acc && (kind == scdfir_pkg::KIND_FRAME);
	assign out_take  = out_valid && !out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			scdfir_pkg::ST_IDLE:    if (frame_acc) state_d = scdfir_pkg::ST_ENV;
			scdfir_pkg::ST_ENV:     state_d = scdfir_pkg::ST_ENV_UPD;
			scdfir_pkg::ST_ENV_UPD: state_d = scdfir_pkg::ST_GAIN;
			scdfir_pkg::ST_GAIN:    state_d = scdfir_pkg::ST_DUCK;
			scdfir_pkg::ST_DUCK:    state_d = scdfir_pkg::ST_MONO;
			scdfir_pkg::ST_MONO:    state_d = scdfir_pkg::ST_DRIVE;
			scdfir_pkg::ST_DRIVE:   state_d = scdfir_pkg::ST_TANH;
			scdfir_pkg::ST_TANH:    state_d = scdfir_pkg::ST_INTERP;
			scdfir_pkg::ST_INTERP:  state_d = scdfir_pkg::ST_BLEND;
			scdfir_pkg::ST_BLEND:   state_d = scdfir_pkg::ST_NORM;
			scdfir_pkg::ST_NORM:    state_d = scdfir_pkg::ST_SHIFT;
			scdfir_pkg::ST_SHIFT:   state_d = scdfir_pkg::ST_FIR;
			scdfir_pkg::ST_FIR: begin
				if (cnt_q == scdfir_pkg::CNT_W'(scdfir_pkg::TAPS)) begin
					state_d = scdfir_pkg::ST_FIR_RND;
				end
			end
			scdfir_pkg::ST_FIR_RND: state_d = scdfir_pkg::ST_MIX;
			scdfir_pkg::ST_MIX:     state_d = scdfir_pkg::ST_OUT;
			scdfir_pkg::ST_OUT:     if (out_load) state_d = scdfir_pkg::ST_IDLE;
			default:                state_d = scdfir_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall           = 1'b1;
		out_load           = 1'b0;
		chain_ctrl         = '0;
		chain_ctrl.rd_addr = cnt_q[scdfir_pkg::TAP_W-1:0];
		chain_ctrl.use_tap = scdfir_pkg::TAP_W'(cnt_q - scdfir_pkg::CNT_W'(1));
		case (state_q)
			scdfir_pkg::ST_IDLE:  in_stall = 1'b0;
			scdfir_pkg::ST_SHIFT: begin
				chain_ctrl.shift = 1'b1;
				chain_ctrl.clear = 1'b1;
			end
			scdfir_pkg::ST_FIR: begin
				chain_ctrl.rd_en  = (cnt_q < scdfir_pkg::CNT_W'(scdfir_pkg::TAPS));
				chain_ctrl.rotate = (cnt_q != '0);
			end
			scdfir_pkg::ST_OUT:   out_load = !out_valid || !out_stall;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scdfir_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == scdfir_pkg::ST_SHIFT) begin
				cnt_q <= '0;
			end else if (state_q == scdfir_pkg::ST_FIR) begin
				cnt_q <= cnt_q + scdfir_pkg::CNT_W'(1);
			end
		end
	end

	// sidechain magnitude at accept
	logic signed [24:0] sl_ext, sr_ext, sl_abs, sr_abs, smax;
	logic [22:0]        ein_in;
	assign sl_ext = 25'(side_left);
	assign sr_ext = 25'(side_right);
	assign sl_abs = (sl_ext < 0) ? -sl_ext : sl_ext;
	assign sr_abs = (sr_ext < 0) ? -sr_ext : sr_ext;
	assign smax   = (sl_abs > sr_abs) ? sl_abs : sr_abs;
	assign ein_in = (smax > 25'sd8388607) ? 23'h7FFFFF : smax[22:0];

	// dry delay line
	logic signed [23:0] dry_l [scdfir_pkg::DRY_DELAY];
	logic signed [23:0] dry_r [scdfir_pkg::DRY_DELAY];
	logic signed [23:0] old_l_q, old_r_q, ml_q, mr_q;
	logic [22:0]        ein_q, env_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < scdfir_pkg::DRY_DELAY; i++) begin
				dry_l[i] <= '0;
				dry_r[i] <= '0;
			end
		end else if (frame_acc) begin
			dry_l[0] <= main_left;
			dry_r[0] <= main_right;
			for (int i = 1; i < scdfir_pkg::DRY_DELAY; i++) begin
				dry_l[i] <= dry_l[i-1];
				dry_r[i] <= dry_r[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (frame_acc) begin
			old_l_q <= dry_l[scdfir_pkg::DRY_DELAY-1];
			old_r_q <= dry_r[scdfir_pkg::DRY_DELAY-1];
			ml_q    <= main_left;
			mr_q    <= main_right;
			ein_q   <= ein_in;
		end
	end

	// envelope
	logic signed [24:0] env_diff;
	logic [15:0]        env_coef;
	logic signed [41:0] env_prod, env_prod_q;
	logic signed [63:0] env_sum;
	assign env_diff = $signed({2'b00, ein_q}) - $signed({2'b00, env_q});
	assign env_coef = (ein_q > env_q) ? attack_q : release_q;
	assign env_prod = 42'(env_diff) * 42'($signed({1'b0, env_coef}));
	assign env_sum  = 64'($signed({1'b0, env_q})) + scdfir_pkg::rshr(64'(env_prod_q), 16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q <= '0;
		end else if (state_q == scdfir_pkg::ST_ENV_UPD) begin
			if (env_sum < 0) begin
				env_q <= '0;
			end else if (env_sum > 64'sd8388607) begin
				env_q <= 23'h7FFFFF;
			end else begin
				env_q <= env_sum[22:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == scdfir_pkg::ST_ENV) begin
			env_prod_q <= env_prod;
		end
	end

	// duck gain, ducked pair, mono, drive
	logic [39:0]        g_prod;
	logic [16:0]        g_q;
	logic signed [41:0] dl_prod, dr_prod;
	logic signed [23:0] dl_q, dr_q, mono_q;
	logic signed [40:0] d_prod;
	logic signed [28:0] d_q;
	assign g_prod  = 40'(duck_cap) * 40'(env_q);
	assign dl_prod = 42'(ml_q) * 42'($signed({1'b0, g_q}));
	assign dr_prod = 42'(mr_q) * 42'($signed({1'b0, g_q}));
	assign d_prod  = 41'(mono_q) * 41'($signed({1'b0, drive_q}));

	// tanh table lookup
	logic                                  t_neg;
	logic signed [28:0]                    d_abs;
	logic [27:0]                           t_mag, t_idx_full;
	logic                                  t_sat;
	logic [scdfir_pkg::TANH_IDX_W-1:0]     t_idx, t_idx_hi;
	logic [scdfir_pkg::TANH_SPAN-1:0]      t_frac;
	logic signed [23:0]                    t_lo, t_hi;
	assign t_neg      = d_q < 0;
	assign d_abs      = t_neg ? -d_q : d_q;
	assign t_mag      = d_abs[27:0];
	assign t_idx_full = t_mag >> (scdfir_pkg::TANH_SPAN - scdfir_pkg::TANH_LOG2);
	assign t_sat      = t_idx_full >= 28'(scdfir_pkg::TANH_DEPTH);
	assign t_idx      = t_sat ? scdfir_pkg::TANH_IDX_W'(scdfir_pkg::TANH_DEPTH)
		: t_idx_full[scdfir_pkg::TANH_IDX_W-1:0];
	assign t_idx_hi   = t_sat ? t_idx : t_idx + scdfir_pkg::TANH_IDX_W'(1);
	assign t_frac     = t_sat ? '0 : scdfir_pkg::TANH_SPAN'(t_mag << scdfir_pkg::TANH_LOG2);
	assign t_lo       = scdfir_pkg::TANH_LUT[t_idx];
	assign t_hi       = scdfir_pkg::TANH_LUT[t_idx_hi];

	logic signed [23:0] lo_q;
	logic signed [24:0] tdiff_q;
	logic [scdfir_pkg::TANH_SPAN-1:0] frac_q;
	logic               neg_q;
	logic signed [51:0] i_prod;
	logic signed [63:0] i_val;
	logic signed [24:0] soft_q, hard;
	logic signed [25:0] hs_diff;
	logic signed [43:0] b_prod;
	logic signed [26:0] c_q;
	logic signed [44:0] n_prod;
	logic signed [23:0] shaped_q;
	assign i_prod  = 52'(tdiff_q) * 52'($signed({1'b0, frac_q}));
	assign i_val   = 64'(lo_q) + scdfir_pkg::rshr(64'(i_prod), scdfir_pkg::TANH_SPAN);
	assign hard    = (d_q > 29'sd8388608) ? 25'sd8388608
		: ((d_q < -29'sd8388608) ? -25'sd8388608 : d_q[24:0]);
	assign hs_diff = 26'(hard) - 26'(soft_q);
	assign b_prod  = 44'(hs_diff) * 44'($signed({1'b0, blend_cap}));
	assign n_prod  = 45'(c_q) * 45'($signed({1'b0, recip_cap}));

	// filter outputs and mix
	logic signed [scdfir_pkg::ACC_W-1:0]  acc_mid, acc_side;
	logic signed [scdfir_pkg::FIRO_W-1:0] midf_q, sidef_q;
	logic signed [scdfir_pkg::FIRO_W:0]   sum_l, sum_r;
	logic signed [52:0]                   mix_l, mix_r, mix_l_q, mix_r_q;
	assign sum_l = (scdfir_pkg::FIRO_W+1)'(midf_q) + (scdfir_pkg::FIRO_W+1)'(sidef_q);
	assign sum_r = (scdfir_pkg::FIRO_W+1)'(midf_q) - (scdfir_pkg::FIRO_W+1)'(sidef_q);
	assign mix_l = 53'(sum_l) * 53'($signed({1'b0, wet_cap}))
		+ 53'(old_l_q) * 53'($signed({1'b0, dry_share}));
	assign mix_r = 53'(sum_r) * 53'($signed({1'b0, wet_cap}))
		+ 53'(old_r_q) * 53'($signed({1'b0, dry_share}));

	// datapath steps
	always_ff @(posedge clk) begin
		case (state_q)
			scdfir_pkg::ST_GAIN:
				g_q <= scdfir_pkg::ONE_Q16 - 17'((g_prod + 40'd4194304) >> 23);
			scdfir_pkg::ST_DUCK: begin
				dl_q <= 24'(scdfir_pkg::rshr(64'(dl_prod), 16));
				dr_q <= 24'(scdfir_pkg::rshr(64'(dr_prod), 16));
			end
			scdfir_pkg::ST_MONO:
				mono_q <= 24'(scdfir_pkg::rshr(64'(dl_q) + 64'(dr_q), 1));
			scdfir_pkg::ST_DRIVE:
				d_q <= 29'(scdfir_pkg::rshr(64'(d_prod), 12));
			scdfir_pkg::ST_TANH: begin
				lo_q    <= t_lo;
				tdiff_q <= 25'(t_hi) - 25'(t_lo);
				frac_q  <= t_frac;
				neg_q   <= t_neg;
			end
			scdfir_pkg::ST_INTERP:
				soft_q <= neg_q ? -25'(i_val) : 25'(i_val);
			scdfir_pkg::ST_BLEND:
				c_q <= 27'(64'(soft_q) + scdfir_pkg::rshr(64'(b_prod), 16));
			scdfir_pkg::ST_NORM:
				shaped_q <= shaper_q ? scdfir_pkg::sat24(scdfir_pkg::rshr(64'(n_prod), 16))
					: mono_q;
			scdfir_pkg::ST_FIR_RND: begin
				midf_q  <= scdfir_pkg::FIRO_W'(scdfir_pkg::rshr(64'(acc_mid), 17));
				sidef_q <= scdfir_pkg::FIRO_W'(scdfir_pkg::rshr(64'(acc_side), 17));
			end
			scdfir_pkg::ST_MIX: begin
				mix_l_q <= mix_l;
				mix_r_q <= mix_r;
			end
			default: ;
		endcase
	end

	scdfir_chain u_chain (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (chain_ctrl),
		.new_mid    (mono_q),
		.new_shaped (shaped_q),
		.coef_we    (in_acc && (kind == scdfir_pkg::KIND_COEF) &&
			(tap_index <= 7'(scdfir_pkg::FIR_ORDER))),
		.coef_addr  (tap_index[scdfir_pkg::TAP_W-1:0]),
		.coef_data  (tap_value),
		.acc_mid    (acc_mid),
		.acc_side   (acc_side)
	);

	// output word register
	logic               out_valid_q;
	logic signed [23:0] out_left_q, out_right_q;
	logic [16:0]        out_duck_q;
	logic [22:0]        out_env_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_left_q  <= scdfir_pkg::sat24(scdfir_pkg::rshr(64'(mix_l_q), 16));
			out_right_q <= scdfir_pkg::sat24(scdfir_pkg::rshr(64'(mix_r_q), 16));
			out_duck_q  <= g_q;
			out_env_q   <= env_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_left        = out_left_q;
	assign out_right       = out_right_q;
	assign duck_level      = out_duck_q;
	assign sidechain_level = out_env_q;

	`SCD_ASSERT_IMPL(a_fir_cnt_range, clk, arst_n, state_q == scdfir_pkg::ST_FIR, cnt_q <= scdfir_pkg::CNT_W'(scdfir_pkg::TAPS))
	`SCD_ASSERT_NEXT(a_fir_start, clk, arst_n, state_q == scdfir_pkg::ST_SHIFT, state_q == scdfir_pkg::ST_FIR && cnt_q == '0)
	`SCD_ASSERT_IMPL(a_out_from_seq, clk, arst_n, $rose(out_valid_q), $past(state_q) == scdfir_pkg::ST_OUT)
	`SCD_ASSERT_IMPL(a_duck_range, clk, arst_n, out_valid_q, out_duck_q <= scdfir_pkg::ONE_Q16)

endmodule
